// ===== rtl/sorted_list_engine_core_macros.svh =====
// Assertion macros for the sorted list engine.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list engine: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list engine: next-cycle check failed");

`endif

// ===== rtl/sle_pkg.sv =====
// Shared types and constants of the sorted list engine.
// Used by the controller, the datapath and the top level; no dependencies.
package sle_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OUT_W    = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] element_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RA_JM1,
    RA_I,
    RA_I1
  } raddr_sel_e;

  typedef struct packed {
    logic       load;
    logic       i_inc;
    logic       j_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       ram_re;
    logic       ram_we;
    raddr_sel_e raddr_sel;
    logic       waddr_i;
    logic       wdata_rd;
    logic       set_status;
    status_e    status;
    logic       set_pos;
  } ctl_t;

  typedef struct packed {
    logic [MODE_W-1:0] req_mode;
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              i_at_count;
    logic              i1_at_count;
    logic              j_zero;
    logic              d_lt;
    logic              d_eq;
  } sts_t;

endpackage

// ===== rtl/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sle_ctrl.sv =====
// Controller state machine of the sorted list engine: sequences scans and shifts.
// Depends on sle_pkg; drives the datapath through sle_pkg::ctl_t.
module sle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  sle_pkg::sts_t sts_i,
  output sle_pkg::ctl_t ctl_o
);

  sle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.raddr_sel = sle_pkg::RA_I;
    ctl_o.status    = sle_pkg::ST_DONE;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      sle_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl_o.load = 1'b1;
          unique case (sts_i.req_mode)
            sle_pkg::MODE_INSERT: begin
              if (sts_i.full) begin
                ctl_o.set_status = 1'b1;
                ctl_o.status     = sle_pkg::ST_FULL;
                state_d          = sle_pkg::S_RESP;
              end else begin
                state_d = sle_pkg::S_INS_RD;
              end
            end
            sle_pkg::MODE_DELETE, sle_pkg::MODE_SEARCH: begin
              state_d = sle_pkg::S_SCAN_RD;
            end
            default: begin
              ctl_o.set_status = 1'b1;
              state_d          = sle_pkg::S_RESP;
            end
          endcase
        end
      end
      sle_pkg::S_SCAN_RD: begin
        if (sts_i.i_at_count) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = sle_pkg::ST_NOTFOUND;
          state_d          = sle_pkg::S_RESP;
        end else begin
          ctl_o.ram_re    = 1'b1;
          ctl_o.raddr_sel = sle_pkg::RA_I;
          state_d         = sle_pkg::S_SCAN_CMP;
        end
      end
      sle_pkg::S_SCAN_CMP: begin
        priority if (sts_i.d_lt) begin
          ctl_o.i_inc = 1'b1;
          state_d     = sle_pkg::S_SCAN_RD;
        end else if (sts_i.d_eq) begin
          if (sts_i.mode == sle_pkg::MODE_SEARCH) begin
            ctl_o.set_status = 1'b1;
            ctl_o.set_pos    = 1'b1;
            state_d          = sle_pkg::S_RESP;
          end else begin
            state_d = sle_pkg::S_DEL_RD;
          end
        end else begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = sle_pkg::ST_NOTFOUND;
          state_d          = sle_pkg::S_RESP;
        end
      end
      sle_pkg::S_DEL_RD: begin
        if (sts_i.i1_at_count) begin
          ctl_o.cnt_dec    = 1'b1;
          ctl_o.set_status = 1'b1;
          state_d          = sle_pkg::S_RESP;
        end else begin
          ctl_o.ram_re    = 1'b1;
          ctl_o.raddr_sel = sle_pkg::RA_I1;
          state_d         = sle_pkg::S_DEL_WR;
        end
      end
      sle_pkg::S_DEL_WR: begin
        ctl_o.ram_we   = 1'b1;
        ctl_o.waddr_i  = 1'b1;
        ctl_o.wdata_rd = 1'b1;
        ctl_o.i_inc    = 1'b1;
        state_d        = sle_pkg::S_DEL_RD;
      end
      sle_pkg::S_INS_RD: begin
        if (sts_i.j_zero) begin
          state_d = sle_pkg::S_INS_PUT;
        end else begin
          ctl_o.ram_re    = 1'b1;
          ctl_o.raddr_sel = sle_pkg::RA_JM1;
          state_d         = sle_pkg::S_INS_CMP;
        end
      end
      sle_pkg::S_INS_CMP: begin
        if (!sts_i.d_lt) begin
          ctl_o.ram_we   = 1'b1;
          ctl_o.wdata_rd = 1'b1;
          ctl_o.j_dec    = 1'b1;
          state_d        = sle_pkg::S_INS_RD;
        end else begin
          state_d = sle_pkg::S_INS_PUT;
        end
      end
      sle_pkg::S_INS_PUT: begin
        ctl_o.ram_we     = 1'b1;
        ctl_o.cnt_inc    = 1'b1;
        ctl_o.set_status = 1'b1;
        state_d          = sle_pkg::S_RESP;
      end
      sle_pkg::S_RESP: begin
        done_o  = 1'b1;
        state_d = sle_pkg::S_IDLE;
      end
      default: begin
        state_d = sle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sle_dpath.sv =====
// Datapath of the sorted list engine: value store, scan and shift pointers, count, result.
// Depends on sle_pkg and sle_ram; commanded by sle_ctrl.
module sle_dpath #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sle_pkg::req_t req_i,
  input  sle_pkg::ctl_t ctl_i,
  output sle_pkg::sts_t sts_o,
  output sle_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned OW = sle_pkg::OUT_W;

  logic signed [sle_pkg::VALUE_W-1:0] value_q;
  logic [sle_pkg::MODE_W-1:0]         mode_q;
  logic [CW-1:0]                      i_q, j_q, count_q;
  logic [CW-1:0]                      i1, jm1;
  sle_pkg::status_e                   status_q;
  logic [OW-1:0]                      position_q;
  logic [CW+OW-1:0]                   pos_ext, cnt_ext;

  logic [AW-1:0]                      raddr, waddr;
  logic [sle_pkg::VALUE_W-1:0]        wdata, rdata;
  logic signed [sle_pkg::VALUE_W-1:0] rdata_s;

  assign i1      = i_q + CW'(1);
  assign jm1     = j_q - CW'(1);
  assign rdata_s = $signed(rdata);
  assign pos_ext = {{OW{1'b0}}, i1};
  assign cnt_ext = {{OW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (ctl_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (ctl_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (ctl_i.load) begin
        i_q <= '0;
      end else if (ctl_i.i_inc) begin
        i_q <= i1;
      end
      if (ctl_i.load) begin
        j_q <= count_q;
      end else if (ctl_i.j_dec) begin
        j_q <= jm1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      value_q <= req_i.value;
      mode_q  <= req_i.mode;
    end
    if (ctl_i.set_status) begin
      status_q   <= ctl_i.status;
      position_q <= ctl_i.set_pos ? pos_ext[OW-1:0] : '0;
    end
  end

  always_comb begin
    unique case (ctl_i.raddr_sel)
      sle_pkg::RA_JM1: raddr = jm1[AW-1:0];
      sle_pkg::RA_I1:  raddr = i1[AW-1:0];
      default:         raddr = i_q[AW-1:0];
    endcase
  end

  assign waddr = ctl_i.waddr_i ? i_q[AW-1:0] : j_q[AW-1:0];
  assign wdata = ctl_i.wdata_rd ? rdata : value_q;

  sle_ram #(
    .WIDTH(sle_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctl_i.ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sts_o.req_mode    = req_i.mode;
  assign sts_o.mode        = mode_q;
  assign sts_o.full        = (count_q == CW'(CAPACITY));
  assign sts_o.i_at_count  = (i_q == count_q);
  assign sts_o.i1_at_count = (i1 == count_q);
  assign sts_o.j_zero      = (j_q == '0);
  assign sts_o.d_lt        = (rdata_s < value_q);
  assign sts_o.d_eq        = (rdata_s == value_q);

  assign rsp_o.status        = status_q;
  assign rsp_o.position      = position_q;
  assign rsp_o.element_count = cnt_ext[OW-1:0];

endmodule

// ===== rtl/sorted_list_engine_core.sv =====
// Sorted list engine: ascending store of signed 32-bit values, insert/delete/search.
// A word is taken when start is high and busy is low. busy stays high until the
// result strobe done_o, which holds rsp_o for exactly one cycle; the receiver cannot
// stall, so capture rsp_o whenever done_o is high. Each request is worked through the value RAM
// entry by entry, through a read state and then a compare or write state for every entry
// visited or moved: search and delete scan from the bottom, delete then moves the entries
// above the match down, and insert shifts from the top; a refused insert or mode three
// goes straight to the response state. No clearing pass.
// Depends on sle_pkg, sle_ctrl, sle_dpath, sle_ram and the assertion macro header.
`include "sorted_list_engine_core_macros.svh"

module sorted_list_engine_core #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sle_pkg::req_t req_i,
  output logic          done_o,
  output sle_pkg::rsp_t rsp_o
);

  sle_pkg::ctl_t ctl;
  sle_pkg::sts_t sts;

  sle_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .sts_i (sts),
    .ctl_o (ctl)
  );

  sle_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

  `SLE_ASSERT_IMPL(a_done_while_busy, clk_i, rst_ni, done_o, busy)
  `SLE_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy)
  `SLE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `SLE_ASSERT_IMPL(a_fail_no_pos, clk_i, rst_ni, done_o && rsp_o.status != sle_pkg::ST_DONE, rsp_o.position == '0)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_engine_core: a short directed table, then phased
// random traffic; each result word is checked against its table entry or a behavioral sorted-store model.
// Depends on sle_pkg and the RTL of sorted_list_engine_core.
module testbench;
  import sle_pkg::*;

  localparam int unsigned CAP = sle_pkg::CAPACITY;
  localparam int RAND_WORDS = 950;
  localparam int PHASE_LEN = 100;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } traffic_e;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  logic signed [VALUE_W-1:0] store_vals [CAP];
  int unsigned store_cnt = 0;
  rsp_t rsp_expected_q [$];
  dir_row_t dir_tab [$];

  int mismatches    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int full_refusals = 0;
  int misses        = 0;
  int found_hits    = 0;

  always #4 clk_i = ~clk_i;

  sorted_list_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  function automatic int unsigned rank_below(logic signed [VALUE_W-1:0] v);
    int unsigned i = 0;
    while (i < store_cnt && store_vals[i] < v) i++;
    return i;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int unsigned idx;
    o.status   = ST_DONE;
    o.position = '0;
    case (r.mode)
      MODE_INSERT: begin
        if (store_cnt >= CAP) begin
          o.status = ST_FULL;
          full_refusals++;
        end else begin
          idx = rank_below(r.value);
          for (int unsigned k = store_cnt; k > idx; k--) store_vals[k] = store_vals[k-1];
          store_vals[idx] = r.value;
          store_cnt++;
        end
      end
      MODE_DELETE, MODE_SEARCH: begin
        idx = rank_below(r.value);
        if (idx >= store_cnt || store_vals[idx] != r.value) begin
          o.status = ST_NOTFOUND;
          misses++;
        end else if (r.mode == MODE_DELETE) begin
          for (int unsigned k = idx; k + 1 < store_cnt; k++) store_vals[k] = store_vals[k+1];
          store_cnt--;
        end else begin
          o.position = OUT_W'(idx + 1);
          found_hits++;
        end
      end
      default: begin
      end
    endcase
    o.element_count = OUT_W'(store_cnt);
    return o;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v, bit typed,
                                  status_e st, int unsigned pos, int unsigned cnt);
    dir_row_t row;
    row.req.mode          = m;
    row.req.value         = v;
    row.typed             = typed;
    row.rsp.status        = st;
    row.rsp.position      = OUT_W'(pos);
    row.rsp.element_count = OUT_W'(cnt);
    dir_tab.push_back(row);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(traffic_e ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 85) return MODE_INSERT;
        if (r < 90) return MODE_DELETE;
        if (r < 98) return MODE_SEARCH;
      end
      PH_SHRINK: begin
        if (r < 10) return MODE_INSERT;
        if (r < 85) return MODE_DELETE;
        if (r < 97) return MODE_SEARCH;
      end
      default: begin
        if (r < 35) return MODE_INSERT;
        if (r < 65) return MODE_DELETE;
        if (r < 95) return MODE_SEARCH;
      end
    endcase
    return MODE_NOP;
  endfunction

  // biased toward stored values so deletes and searches hit, with duplicates and extremes
  function automatic logic signed [VALUE_W-1:0] pick_value(int unsigned hit_pct);
    int unsigned r;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (store_cnt != 0 && r < hit_pct) return store_vals[$urandom_range(0, store_cnt - 1)];
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $signed(VALUE_W'($urandom_range(0, 15))) - 32'sd8;
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic send_word(req_t r, int unsigned gap, bit typed, rsp_t typed_rsp);
    rsp_t pred;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = apply_request(r);
    rsp_expected_q.push_back(typed ? typed_rsp : pred);
    words_sent++;
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (rsp_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status=%0d position=%0d count=%0d",
                   rsp_o.status, rsp_o.position, rsp_o.element_count);
      end else begin
        want = rsp_expected_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.position !== want.position ||
            rsp_o.element_count !== want.element_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected status=%0d position=%0d count=%0d, got status=%0d position=%0d count=%0d",
                     results_seen, want.status, want.position, want.element_count,
                     rsp_o.status, rsp_o.position, rsp_o.element_count);
        end
      end
    end
  end

  initial begin
    rsp_t none;
    req_t r;
    traffic_e phase;
    bit bursty;
    int unsigned hit_pct;
    none    = '0;
    phase   = PH_GROW;
    bursty  = 1'b0;
    hit_pct = 30;

    add_row(MODE_SEARCH, 32'h0000_0000, 1'b1, ST_NOTFOUND, 0, 0);
    add_row(MODE_DELETE, 32'h8000_0000, 1'b1, ST_NOTFOUND, 0, 0);
    add_row(MODE_NOP,    32'hFFFF_FFFF, 1'b1, ST_DONE,     0, 0);
    add_row(MODE_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DONE,     0, 1);
    add_row(MODE_INSERT, 32'h8000_0000, 1'b1, ST_DONE,     0, 2);
    add_row(MODE_SEARCH, 32'h8000_0000, 1'b1, ST_DONE,     1, 2);
    add_row(MODE_SEARCH, 32'h7FFF_FFFF, 1'b1, ST_DONE,     2, 2);
    add_row(MODE_INSERT, 32'h0000_0000, 1'b1, ST_DONE,     0, 3);
    add_row(MODE_INSERT, 32'h0000_0000, 1'b1, ST_DONE,     0, 4);
    add_row(MODE_SEARCH, 32'h0000_0000, 1'b1, ST_DONE,     2, 4);
    add_row(MODE_SEARCH, 32'h0000_0001, 1'b1, ST_NOTFOUND, 0, 4);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_SEARCH, 32'hFFFF_FFFF, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_DELETE, 32'h0000_0000, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_SEARCH, 32'h0000_0000, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_NOP,    32'h7FFF_FFFF, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_DELETE, 32'h7FFF_FFFF, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_DELETE, 32'h7FFF_FFFF, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_INSERT, 32'h5555_5555, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_INSERT, 32'hAAAA_AAAA, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_SEARCH, 32'hAAAA_AAAA, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_DELETE, 32'h8000_0000, 1'b0, ST_DONE,     0, 0);
    add_row(MODE_SEARCH, 32'h5555_5555, 1'b0, ST_DONE,     0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[d])
      send_word(dir_tab[d].req, $urandom_range(0, 9), dir_tab[d].typed, dir_tab[d].rsp);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 4)
          0:       phase = PH_GROW;
          2:       phase = PH_SHRINK;
          default: phase = traffic_e'($urandom_range(0, 2));
        endcase
        hit_pct = (phase == PH_GROW) ? 30 : (phase == PH_SHRINK) ? 80 : 50;
        bursty  = ($urandom_range(0, 2) == 0);
      end
      r.mode  = pick_mode(phase);
      r.value = pick_value(hit_pct);
      send_word(r, bursty ? 0 : $urandom_range(0, 9), 1'b0, none);
    end
    start <= 1'b0;

    while (rsp_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d words (%0d from the directed table), checked %0d result words",
             words_sent, dir_tab.size(), results_seen);
    $display("%0d inserts refused on a full store, %0d lookups missed, %0d searches hit",
             full_refusals, misses, found_hits);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatching result words", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d result words outstanding", rsp_expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sle_dpath.sv
rtl/sorted_list_engine_core.sv
dv/testbench.sv
